/* hdl/gcs_pkg.sv */
package gcs_pkg;

	// Dimension and glyph-count limits
	localparam int MAX_DIM    = 4096;
	localparam int MAX_GLYPHS = 256;

	// Field and register widths
	localparam int THR_W = 8;
	localparam int DIM_W = 13;
	localparam int CNT_W = 9;
	localparam int POS_W = 12;
	localparam int IDX_W = 8;
	localparam int CH_W  = 8;
	localparam int SUM_W = 10;

	localparam logic [DIM_W-1:0] DIM_MAX_V = DIM_W'(MAX_DIM);
	localparam logic [CNT_W-1:0] CNT_MAX_V = CNT_W'(MAX_GLYPHS);

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_WIDTH     = 2'd1,
		CFG_HEIGHT    = 2'd2,
		CFG_COUNT     = 2'd3
	} cfg_reg_t;

	// Segmenter state: seeking a glyph start or inside a glyph
	typedef enum logic [1:0] {
		ST_SEEK   = 2'b01,
		ST_INSIDE = 2'b10
	} seg_state_t;

	// One segmented glyph
	typedef struct packed {
		logic [IDX_W-1:0] glyph_index;
		logic [POS_W-1:0] start_column;
		logic [POS_W-1:0] glyph_width;
		logic             last_glyph;
	} glyph_rec_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_MAX_V)
			r = DIM_MAX_V;
		return r;
	endfunction

endpackage

/* hdl/glyph_column_segmenter.sv */
// An accepted pixel is registered; a glyph it closes then loads the result register.
// Throughput: one pixel per cycle; the pixel stage stalls only when it closes a
// glyph while the previous result is still waiting in the result register.
// Reset (arst_n low, asynchronous): all pipeline valids cleared, scan restarts at
// column 0 seeking a glyph, registers return to threshold 0, size 1x1, count 0.
module glyph_column_segmenter import gcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  mask_red,
	input  logic [CH_W-1:0]  mask_green,
	input  logic [CH_W-1:0]  mask_blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] glyph_index,
	output logic [POS_W-1:0] start_column,
	output logic [POS_W-1:0] glyph_width,
	output logic             last_glyph
);

	logic [THR_W-1:0] alpha_threshold_q;
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [CNT_W-1:0] glyph_count_q;

	logic       valid_s1;
	logic       inked;
	logic       emit;
	logic       advance;
	logic       step;
	glyph_rec_t rec;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_threshold_q <= '0;
			image_width_q     <= DIM_W'(1);
			image_height_q    <= DIM_W'(1);
			glyph_count_q     <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_THRESHOLD: alpha_threshold_q <= cfg_data[THR_W-1:0];
				CFG_WIDTH:     image_width_q     <= cfg_data;
				CFG_HEIGHT:    image_height_q    <= cfg_data;
				CFG_COUNT:     glyph_count_q     <= cfg_data[CNT_W-1:0];
				default:       ;
			endcase
		end
	end

	// Move the pixel on unless it produces a result that has nowhere to go
	assign advance = !emit || !out_valid || out_ready;
	assign step    = valid_s1 && advance;

	gcs_pixel_stage u_pixel (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mask_red   (mask_red),
		.mask_green (mask_green),
		.mask_blue  (mask_blue),
		.threshold  (alpha_threshold_q),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.inked      (inked)
	);

	gcs_scan_ctrl u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.glyph_count  (glyph_count_q),
		.valid_s1     (valid_s1),
		.inked        (inked),
		.step         (step),
		.emit         (emit),
		.rec          (rec)
	);

	gcs_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step && emit),
		.rec          (rec),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.glyph_index  (glyph_index),
		.start_column (start_column),
		.glyph_width  (glyph_width),
		.last_glyph   (last_glyph)
	);

endmodule

/* hdl/gcs_pixel_stage.sv */
module gcs_pixel_stage import gcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  mask_red,
	input  logic [CH_W-1:0]  mask_green,
	input  logic [CH_W-1:0]  mask_blue,
	input  logic [THR_W-1:0] threshold,
	input  logic             advance,
	output logic             valid_s1,
	output logic             inked
);

	logic [CH_W-1:0]  red_s1;
	logic [CH_W-1:0]  green_s1;
	logic [CH_W-1:0]  blue_s1;
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] limit;
	logic             accept;

	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// Hold the stage valid until the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	// Capture the pixel bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= mask_red;
			green_s1 <= mask_green;
			blue_s1  <= mask_blue;
		end
	end

	// floor(sum/3) > t is the same as sum > 3t+2
	assign sum   = SUM_W'(red_s1) + SUM_W'(green_s1) + SUM_W'(blue_s1);
	assign limit = {1'b0, threshold, 1'b0} + SUM_W'(threshold) + SUM_W'(2);
	assign inked = sum > limit;

endmodule

/* hdl/gcs_scan_ctrl.sv */
module gcs_scan_ctrl import gcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] image_width,
	input  logic [DIM_W-1:0] image_height,
	input  logic [CNT_W-1:0] glyph_count,
	input  logic             valid_s1,
	input  logic             inked,
	input  logic             step,
	output logic             emit,
	output glyph_rec_t       rec
);

	logic [POS_W-1:0] column_pos_q;
	logic [POS_W-1:0] row_pos_q;
	logic             column_inked_q;
	seg_state_t       state_q;
	logic [POS_W-1:0] glyph_start_q;
	logic [CNT_W-1:0] glyphs_found_q;
	logic             scan_done_q;

	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic [CNT_W-1:0] cnt;
	logic             ink_any;
	logic             col_end;
	logic             open_glyph;
	logic             close_glyph;
	logic [CNT_W-1:0] found_inc;
	logic [CNT_W-1:0] found_next;
	logic             stop;

	// Effective limits
	assign w   = clamp_dim(image_width);
	assign h   = clamp_dim(image_height);
	assign cnt = (glyph_count > CNT_MAX_V) ? CNT_MAX_V : glyph_count;

	// Column end and glyph boundary decisions
	assign ink_any     = column_inked_q || inked;
	assign col_end     = ({1'b0, row_pos_q} + DIM_W'(1)) >= h;
	assign open_glyph  = col_end && (state_q == ST_SEEK) && ink_any;
	assign close_glyph = col_end && (state_q == ST_INSIDE) && !ink_any;
	assign found_inc   = glyphs_found_q + CNT_W'(1);
	assign found_next  = close_glyph ? found_inc : glyphs_found_q;
	assign stop        = (found_next >= cnt) ||
	                     (({1'b0, column_pos_q} + DIM_W'(1)) >= w);

	assign emit = valid_s1 && !scan_done_q && close_glyph;

	always_comb begin
		rec.glyph_index  = glyphs_found_q[IDX_W-1:0];
		rec.start_column = glyph_start_q;
		rec.glyph_width  = column_pos_q - glyph_start_q;
		rec.last_glyph   = found_inc >= cnt;
	end

	// Advance scan position and glyph state per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pos_q   <= '0;
			row_pos_q      <= '0;
			column_inked_q <= 1'b0;
			state_q        <= ST_SEEK;
			glyph_start_q  <= '0;
			glyphs_found_q <= '0;
			scan_done_q    <= 1'b0;
		end else if (step && !scan_done_q) begin
			if (!col_end) begin
				row_pos_q      <= row_pos_q + POS_W'(1);
				column_inked_q <= ink_any;
			end else begin
				if (open_glyph) begin
					state_q       <= ST_INSIDE;
					glyph_start_q <= column_pos_q;
				end else if (close_glyph) begin
					state_q <= ST_SEEK;
				end
				glyphs_found_q <= found_next;
				row_pos_q      <= '0;
				column_inked_q <= 1'b0;
				if (stop)
					scan_done_q <= 1'b1;
				else
					column_pos_q <= column_pos_q + POS_W'(1);
			end
		end
	end

endmodule

/* hdl/gcs_out_reg.sv */
module gcs_out_reg import gcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  glyph_rec_t       rec,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] glyph_index,
	output logic [POS_W-1:0] start_column,
	output logic [POS_W-1:0] glyph_width,
	output logic             last_glyph
);

	glyph_rec_t rec_q;

	// Hold the result until taken; a new load replaces a taken one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (load)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			rec_q <= rec;
	end

	assign glyph_index  = rec_q.glyph_index;
	assign start_column = rec_q.start_column;
	assign glyph_width  = rec_q.glyph_width;
	assign last_glyph   = rec_q.last_glyph;

endmodule

/* verif/glyph_column_segmenter_tb.sv */
module glyph_column_segmenter_tb;
	import gcs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef enum {COL_BLANK, COL_INK, COL_NOISE} col_kind_t;
	typedef enum {END_LAST_GLYPH, END_RIGHT_EDGE, END_ZERO_COUNT} end_mode_t;

	// Track segmenter state and the glyphs it owes
	class glyph_scoreboard;
		logic [THR_W-1:0] threshold;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		logic [CNT_W-1:0] count_reg;
		int unsigned col_pos, row_pos, start_col, found;
		bit col_inked, seeking, done;
		glyph_rec_t glyphs_due[$];
		int unsigned errors, glyphs_checked, pixels_taken, pixels_dropped;

		function new();
			threshold = '0;
			width_reg = 1;
			height_reg = 1;
			count_reg = '0;
			seeking = 1'b1;
		endfunction

		function int unsigned fit_dim(logic [DIM_W-1:0] v);
			if (v == '0)
				return 1;
			if (v > MAX_DIM)
				return MAX_DIM;
			return v;
		endfunction

		function int unsigned column_rows();
			return fit_dim(height_reg);
		endfunction

		function void set_reg(cfg_reg_t idx, logic [DIM_W-1:0] v);
			case (idx)
				CFG_THRESHOLD: threshold = v[THR_W-1:0];
				CFG_WIDTH:     width_reg = v;
				CFG_HEIGHT:    height_reg = v;
				CFG_COUNT:     count_reg = v[CNT_W-1:0];
				default:       ;
			endcase
		endfunction

		// Advance the scan by one pixel; queue a glyph when a blank column closes one
		function void take_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
			int unsigned alpha, cnt;
			glyph_rec_t rec;
			pixels_taken++;
			if (done) begin
				pixels_dropped++;
				return;
			end
			alpha = r;
			alpha = (alpha + g + b) / 3;
			if (alpha > threshold)
				col_inked = 1'b1;
			cnt = (count_reg > MAX_GLYPHS) ? MAX_GLYPHS : count_reg;
			if (row_pos + 1 < column_rows()) begin
				row_pos++;
				return;
			end
			// column complete
			if (seeking && col_inked) begin
				seeking = 1'b0;
				start_col = col_pos;
			end else if (!seeking && !col_inked) begin
				seeking = 1'b1;
				rec.glyph_index = IDX_W'(found);
				rec.start_column = POS_W'(start_col);
				rec.glyph_width = POS_W'(col_pos - start_col);
				rec.last_glyph = (found + 1 >= cnt);
				glyphs_due.push_back(rec);
				found = (found + 1) & 'h1FF;
			end
			if (found >= cnt || col_pos + 1 >= fit_dim(width_reg))
				done = 1'b1;
			else
				col_pos++;
			row_pos = 0;
			col_inked = 1'b0;
		endfunction

		function void match_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			end
		endfunction

		// Compare one emitted glyph against the oldest one owed
		function void check_glyph(glyph_rec_t got);
			glyph_rec_t want;
			if (glyphs_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected glyph: expected none, actual index %0d start %0d width %0d last %0d",
					$time, got.glyph_index, got.start_column, got.glyph_width, got.last_glyph);
				return;
			end
			want = glyphs_due.pop_front();
			glyphs_checked++;
			match_field("glyph_index", 32'(want.glyph_index), 32'(got.glyph_index));
			match_field("start_column", 32'(want.start_column), 32'(got.start_column));
			match_field("glyph_width", 32'(want.glyph_width), 32'(got.glyph_width));
			match_field("last_glyph", 32'(want.last_glyph), 32'(got.last_glyph));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	cfg_reg_t         cfg_index = CFG_THRESHOLD;
	logic [DIM_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [CH_W-1:0]  mask_red = '0;
	logic [CH_W-1:0]  mask_green = '0;
	logic [CH_W-1:0]  mask_blue = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [IDX_W-1:0] glyph_index;
	logic [POS_W-1:0] start_column;
	logic [POS_W-1:0] glyph_width;
	logic             last_glyph;

	glyph_scoreboard sb = new();
	int unsigned sender_idle = 0;
	int unsigned receiver_stall = 0;
	int unsigned cycles = 0;

	glyph_column_segmenter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mask_red     (mask_red),
		.mask_green   (mask_green),
		.mask_blue    (mask_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.glyph_index  (glyph_index),
		.start_column (start_column),
		.glyph_width  (glyph_width),
		.last_glyph   (last_glyph)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Check each accepted glyph and stall the receiver at random
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_glyph({glyph_index, start_column, glyph_width, last_glyph});
		out_ready <= ($urandom_range(99) >= receiver_stall);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d glyphs outstanding", $time, sb.glyphs_due.size());
			$display("FAIL glyph_column_segmenter");
			$finish;
		end
	end

	// Offer one pixel, idling first at random, and hold it until accepted
	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		if (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle);
		end
		in_valid <= 1'b1;
		mask_red <= r;
		mask_green <= g;
		mask_blue <= b;
		do @(posedge clk); while (!in_ready);
		sb.take_pixel(r, g, b);
	endtask

	// Hold input until every owed glyph has arrived and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.glyphs_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] v);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic configure(input logic [THR_W-1:0] thr, input logic [DIM_W-1:0] wid,
			input logic [DIM_W-1:0] hgt, input logic [CNT_W-1:0] cnt);
		settle();
		write_reg(CFG_THRESHOLD, DIM_W'(thr));
		write_reg(CFG_WIDTH, wid);
		write_reg(CFG_HEIGHT, hgt);
		write_reg(CFG_COUNT, DIM_W'(cnt));
		cfg_write <= 1'b0;
	endtask

	// Blank bytes stay at or under the threshold, ink bytes go above it unless it is 255; noise bytes take any value
	function automatic logic [CH_W-1:0] pick_byte(col_kind_t kind);
		if (kind == COL_NOISE || (kind == COL_INK && sb.threshold == 8'hFF))
			return CH_W'($urandom_range(255));
		if (kind == COL_INK)
			return CH_W'($urandom_range(255, sb.threshold + 1));
		return CH_W'($urandom_range(sb.threshold));
	endfunction

	// Send one full column; an inked column carries ink on one random row and noise on the others
	task automatic send_column(input col_kind_t kind);
		int unsigned rows, mark;
		col_kind_t rest;
		rows = sb.column_rows();
		mark = $urandom_range(rows - 1);
		rest = (kind == COL_INK) ? COL_NOISE : kind;
		for (int unsigned i = 0; i < rows; i++) begin
			if (i == mark)
				send_pixel(pick_byte(kind), pick_byte(kind), pick_byte(kind));
			else
				send_pixel(pick_byte(rest), pick_byte(rest), pick_byte(rest));
		end
	endtask

	// Stream glyph runs and gaps under changing settings, leaving room to finish the scan
	task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned quota);
		int unsigned first, thr;
		sender_idle = idle_pct;
		receiver_stall = stall_pct;
		first = sb.pixels_taken;
		while (sb.pixels_taken - first < quota && sb.found < 230 && sb.col_pos < 3900) begin
			case ($urandom_range(3))
				0:       thr = 0;
				1:       thr = $urandom_range(254);
				default: thr = $urandom_range(200, 60);
			endcase
			configure(THR_W'(thr), $urandom_range(1) ? 13'd8191 : 13'd4096,
				DIM_W'($urandom_range(4)), $urandom_range(1) ? 9'd511 : 9'd256);
			repeat ($urandom_range(6, 2)) begin
				repeat ($urandom_range(4, 1))
					send_column(($urandom_range(9) == 0) ? COL_NOISE : COL_INK);
				repeat ($urandom_range(3, 1))
					send_column(($urandom_range(9) == 0) ? COL_NOISE : COL_BLANK);
			end
			// sometimes send up to one column of random pixels so the next settings may land mid-column
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(sb.column_rows()))
					send_pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
						CH_W'($urandom_range(255)));
		end
	endtask

	initial begin
		end_mode_t finish_mode;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// zero count and out-of-range sizes before any pixel
		configure(0, 13'd8191, 13'd0, 9'd0);

		// one-pixel columns: integer alpha, threshold edges
		configure(0, 13'd4096, 13'd1, 9'd256);
		send_pixel(0, 0, 0);
		send_pixel(1, 1, 0);
		send_pixel(1, 1, 1);
		send_pixel(255, 255, 255);
		send_pixel(0, 0, 2);
		send_pixel(0, 255, 0);
		send_pixel(0, 0, 0);
		configure(254, 13'd4096, 13'd1, 9'd256);
		send_pixel(255, 255, 254);
		send_pixel(255, 255, 255);
		send_pixel(254, 255, 255);
		configure(255, 13'd4096, 13'd1, 9'd256);
		send_pixel(255, 255, 255);

		// taller columns with ink on a middle or last row
		configure(100, 13'd4096, 13'd3, 9'd256);
		send_pixel(0, 0, 0);
		send_pixel(200, 200, 200);
		send_pixel(0, 0, 0);
		send_pixel(0, 0, 0);
		send_pixel(0, 0, 0);
		send_pixel(101, 101, 101);
		send_pixel(100, 100, 100);
		send_pixel(255, 0, 44);
		send_pixel(0, 0, 0);

		// shrink the height mid-column: the column ends at the next pixel
		send_pixel(200, 200, 200);
		send_pixel(0, 0, 0);
		configure(100, 13'd4096, 13'd1, 9'd256);
		send_pixel(0, 0, 0);
		send_pixel(0, 0, 0);

		// oversize height: the column stays open past its first rows until the height shrinks
		configure(0, 13'd4096, 13'd8191, 9'd256);
		repeat (6) send_pixel(0, 0, 0);
		send_pixel(0, 0, 3);
		send_pixel(0, 0, 0);
		configure(0, 13'd8191, 13'd1, 9'd511);
		send_pixel(0, 0, 0);
		send_pixel(0, 0, 0);

		random_phase(0, 0, 100);
		random_phase(88, 0, 100);
		random_phase(0, 88, 100);
		random_phase(15, 15, 100);

		// end the scan one of three ways
		finish_mode = end_mode_t'($urandom_range(2));
		configure(0, 13'd8191, 13'd1, 9'd511);
		send_column(COL_BLANK);
		case (finish_mode)
			END_LAST_GLYPH: begin
				configure(0, 13'd8191, 13'd1, CNT_W'(sb.found + 1));
				send_column(COL_INK);
				send_column(COL_BLANK);
			end
			END_RIGHT_EDGE: begin
				configure(0, DIM_W'(sb.col_pos + 2), 13'd1, 9'd511);
				send_column(COL_INK);
				send_column(COL_INK);
			end
			default: begin
				configure(0, 13'd8191, 13'd1, 9'd0);
				send_column(COL_INK);
			end
		endcase

		// drop everything after the scan, whatever the settings
		configure(255, 13'd0, 13'd8191, 9'd0);
		repeat (20)
			send_pixel(CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
				CH_W'($urandom_range(255)));

		settle();
		repeat (10) @(posedge clk);
		$display("Streamed %0d pixels (%0d after the scan ended) and checked %0d glyphs;",
			sb.pixels_taken, sb.pixels_dropped, sb.glyphs_checked);
		$display("scan ended by %s at column %0d.", finish_mode.name(), sb.col_pos);
		if (sb.errors == 0 && sb.glyphs_due.size() == 0)
			$display("PASS glyph_column_segmenter");
		else
			$display("FAIL glyph_column_segmenter");
		$finish;
	end

endmodule

/* sim.f */
hdl/gcs_pkg.sv
hdl/gcs_pixel_stage.sv
hdl/gcs_scan_ctrl.sv
hdl/gcs_out_reg.sv
hdl/glyph_column_segmenter.sv
verif/glyph_column_segmenter_tb.sv
